@@ hw/rtl/wpsm_pkg.sv @@
// Shared types, item codes and minute-of-day and weekday-bit helpers for the pump schedule matcher.
package wpsm_pkg;

	typedef enum logic [1:0] {
		KIND_EVAL   = 2'd0,
		KIND_WRITE  = 2'd1,
		KIND_PAUSE  = 2'd2,
		KIND_RESUME = 2'd3
	} wpsm_kind_t;

	localparam int unsigned MinuteW = 11;
	localparam int unsigned DaysW   = 7;

	typedef struct packed {
		logic [MinuteW-1:0] start_min;
		logic [MinuteW-1:0] stop_min;
		logic [DaysW-1:0]   mask;
	} wpsm_entry_t;

	typedef struct packed {
		logic [MinuteW-1:0] now;
		logic [DaysW-1:0]   day_bit;
	} wpsm_query_t;

	typedef struct packed {
		logic done;
		logic hit;
	} wpsm_scan_rsp_t;

	// hour * 60 + minute as (hour << 6) - (hour << 2) + minute
	function automatic logic [MinuteW-1:0] minute_of_day(input logic [4:0] hour,
			input logic [5:0] minute);
		logic [MinuteW-1:0] h64;
		logic [MinuteW-1:0] h4;
		h64 = {hour, 6'b0};
		h4  = {4'b0, hour, 2'b0};
		return h64 - h4 + {5'b0, minute};
	endfunction

	function automatic logic [DaysW-1:0] weekday_bit(input logic [2:0] weekday);
		logic [7:0] onehot;
		onehot = 8'b1 << weekday;
		return onehot[DaysW-1:0];
	endfunction

endpackage

@@ hw/rtl/wpsm_ram.sv @@
// Generic single-port-write, registered-read RAM.
module wpsm_ram #(
	parameter int unsigned WIDTH  = 29,
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned ADDR_W = 3
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ hw/rtl/wpsm_table.sv @@
// Window store: RAM with per-entry valid bits so unwritten entries read as zero.
module wpsm_table
	import wpsm_pkg::*;
#(
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned ADDR_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  wpsm_entry_t       wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output wpsm_entry_t       rd_data
);

	logic [DEPTH-1:0] valid_q;
	logic             rd_vld_q;
	logic [$bits(wpsm_entry_t)-1:0] ram_rd;

	wpsm_ram #(
		.WIDTH  ($bits(wpsm_entry_t)),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? wpsm_entry_t'(ram_rd) : '0;

endmodule

@@ hw/rtl/wpsm_scan.sv @@
// Sequencer that walks the window store one entry per cycle and ORs the matches.
module wpsm_scan
	import wpsm_pkg::*;
#(
	parameter int unsigned DEPTH  = 8,
	parameter int unsigned ADDR_W = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  wpsm_query_t       query,
	output logic [ADDR_W-1:0] rd_addr,
	input  wpsm_entry_t       rd_data,
	output wpsm_scan_rsp_t    rsp
);

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(DEPTH - 1);

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              hit_q;
	wpsm_query_t       query_q;
	logic              cur_match;
	logic              last;

	assign cur_match = (rd_data.start_min <= query_q.now) &&
		(query_q.now <= rd_data.stop_min) && (|(rd_data.mask & query_q.day_bit));
	assign last      = (cnt_q == LastAddr);
	assign rd_addr   = (state_q == S_SCAN) ? cnt_q + 1'b1 : '0;
	assign rsp.done  = (state_q == S_SCAN) && last;
	assign rsp.hit   = hit_q | cur_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
			query_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						query_q <= query;
					end
				end
				S_SCAN: begin
					hit_q <= hit_q | cur_match;
					if (last) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/weekly_pump_schedule_matcher.sv @@
// Top level of the weekly pump schedule matcher: item decode, mode registers, result beat.
// An item is taken when start is high and busy is low; each item yields one result beat,
// a one-cycle done strobe with pump_on, window_hit and is_paused, that the receiver must
// take as it comes. Write, pause and resume items answer in the cycle after they are taken
// and never raise busy. An evaluate item walks the window store one entry per cycle through
// the RAM's single read port: busy stays high while the scan runs and done follows once
// the last entry has been read. The store needs no clearing pass after reset. Configuration
// writes are always ready.
module weekly_pump_schedule_matcher
	import wpsm_pkg::*;
#(
	parameter int unsigned NUM_WINDOWS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [4:0]  now_hour,
	input  logic [5:0]  now_minute,
	input  logic [2:0]  now_weekday,
	input  logic [11:0] water_level,
	input  logic [2:0]  entry_index,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [4:0]  stop_hour,
	input  logic [5:0]  stop_minute,
	input  logic [6:0]  day_mask,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	output logic        done,
	output logic        pump_on,
	output logic        window_hit,
	output logic        is_paused
);

	localparam int unsigned AddrW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

	typedef enum logic {
		CFG_BASE_MODE = 1'b0,
		CFG_THRESHOLD = 1'b1
	} cfg_reg_t;

	logic             accept;
	wpsm_kind_t       item_kind;
	logic             eval_go;
	logic             wr_en;
	logic [AddrW-1:0] wr_addr;
	wpsm_entry_t      wr_entry;
	wpsm_query_t      query;
	logic [AddrW-1:0] rd_addr;
	wpsm_entry_t      rd_data;
	wpsm_scan_rsp_t   scan_rsp;

	logic        busy_q;
	logic        done_q;
	logic        pump_q;
	logic        hit_q;
	logic        paused_q;
	logic        base_mode_q;
	logic [11:0] threshold_q;
	logic [11:0] level_q;

	assign accept    = start && !busy_q;
	assign item_kind = wpsm_kind_t'(kind);
	assign eval_go   = accept && (item_kind == KIND_EVAL);
	assign wr_en     = accept && (item_kind == KIND_WRITE) &&
		(32'(entry_index) < 32'(NUM_WINDOWS));
	assign wr_addr   = AddrW'(entry_index);

	assign wr_entry.start_min = minute_of_day(start_hour, start_minute);
	assign wr_entry.stop_min  = minute_of_day(stop_hour, stop_minute);
	assign wr_entry.mask      = day_mask;
	assign query.now          = minute_of_day(now_hour, now_minute);
	assign query.day_bit      = weekday_bit(now_weekday);

	wpsm_table #(
		.DEPTH  (NUM_WINDOWS),
		.ADDR_W (AddrW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wpsm_scan #(
		.DEPTH  (NUM_WINDOWS),
		.ADDR_W (AddrW)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (eval_go),
		.query   (query),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rsp     (scan_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			pump_q      <= 1'b0;
			hit_q       <= 1'b0;
			paused_q    <= 1'b0;
			base_mode_q <= 1'b0;
			threshold_q <= '0;
			level_q     <= '0;
		end else begin
			done_q <= (accept && (item_kind != KIND_EVAL)) || scan_rsp.done;
			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_BASE_MODE: base_mode_q <= cfg_data[0];
					CFG_THRESHOLD: threshold_q <= cfg_data;
					default:       ;
				endcase
			end
			if (accept) begin
				unique case (item_kind)
					KIND_EVAL: begin
						busy_q  <= 1'b1;
						level_q <= water_level;
					end
					KIND_WRITE: begin
						pump_q <= 1'b0;
						hit_q  <= 1'b0;
					end
					KIND_PAUSE: begin
						paused_q <= 1'b1;
						pump_q   <= 1'b0;
						hit_q    <= 1'b0;
					end
					KIND_RESUME: begin
						paused_q <= 1'b0;
						pump_q   <= 1'b0;
						hit_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (scan_rsp.done) begin
				busy_q <= 1'b0;
				hit_q  <= scan_rsp.hit;
				pump_q <= scan_rsp.hit && !paused_q &&
					(!base_mode_q || (level_q >= threshold_q));
			end
		end
	end

	assign busy       = busy_q;
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign pump_on    = pump_q;
	assign window_hit = hit_q;
	assign is_paused  = paused_q;

endmodule

@@ hw/rtl/wpsm_checker.sv @@
// Port-level assertions for the pump schedule matcher and their bind.
module wpsm_checker
	import wpsm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] kind,
	input logic       done,
	input logic       pump_on,
	input logic       window_hit,
	input logic       is_paused
);

	a_quick_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind != KIND_EVAL) |=> done && !pump_on && !window_hit)
		else $error("non-evaluate item did not answer next cycle");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == KIND_EVAL) |=> busy)
		else $error("evaluate item did not raise busy");

	a_busy_ends_in_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	a_pump_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && pump_on |-> window_hit && !is_paused)
		else $error("pump on without a window hit or while paused");

	a_pause_beat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == KIND_PAUSE) |=> is_paused)
		else $error("pause item did not set the pause flag");

endmodule

bind weekly_pump_schedule_matcher wpsm_checker u_wpsm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.kind       (kind),
	.done       (done),
	.pump_on    (pump_on),
	.window_hit (window_hit),
	.is_paused  (is_paused)
);
